// ===== rtl/core/src_pkg.sv =====
`default_nettype none

package src_pkg;

  localparam int unsigned LINE_SENSORS = 5;
  localparam int unsigned ADC_BITS     = 10;

  localparam logic [31:0] CODE_POWER = 32'h57A8FF00;
  localparam logic [31:0] CODE_SUMO  = 32'h22DDFF00;
  localparam logic [31:0] CODE_CALIB = 32'hBE41FF00;

  localparam logic [14:0] ECHO_TIMEOUT = 15'd20000;
  localparam logic [31:0] THR_RESET    = 32'd500;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 12;

  typedef enum logic [1:0] {
    DRV_RELEASE  = 2'd0,
    DRV_FORWARD  = 2'd1,
    DRV_BACKWARD = 2'd2
  } drive_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ATTACK_RANGE = 3'd0,
    CFG_ATTACK_SPEED = 3'd1,
    CFG_BACKUP_SPEED = 3'd2,
    CFG_SEARCH_SPEED = 3'd3,
    CFG_BACKUP_MS    = 3'd4,
    CFG_PAUSE_MS     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic        ir_valid;
    logic [31:0] ir_code;
    logic [9:0]  line_0;
    logic [9:0]  line_1;
    logic [9:0]  line_2;
    logic [9:0]  line_3;
    logic [9:0]  line_4;
    logic [14:0] echo_us;
  } in_t;

  typedef struct packed {
    drive_e      left_drive;
    drive_e      right_drive;
    logic [7:0]  drive_speed;
    logic [11:0] hold_ms;
    logic        power_state;
    logic        sumo_state;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [8:0]  attack_range_cm;
    logic [7:0]  attack_speed;
    logic [7:0]  backup_speed;
    logic [7:0]  search_speed;
    logic [11:0] backup_ms;
    logic [11:0] pause_ms;
  } cfg_t;

  typedef struct packed {
    logic power;
    logic sumo;
    logic calib_phase;
  } flags_t;

  typedef logic [LINE_SENSORS-1:0][ADC_BITS-1:0] samples_t;

endpackage

`default_nettype wire

// ===== rtl/core/src_pass.sv =====
`default_nettype none

module src_pass (
  input  var src_pkg::in_t     item_i,
  input  var src_pkg::cfg_t    cfg_i,
  input  var src_pkg::flags_t  flags_i,
  input  var src_pkg::samples_t black_i,
  input  var src_pkg::samples_t thr_i,
  output src_pkg::flags_t      flags_o,
  output logic                 black_we_o,
  output src_pkg::samples_t    thr_o,
  output src_pkg::out_t        res0_o,
  output src_pkg::out_t        res1_o,
  output logic                 two_o
);

  localparam int unsigned Adc = src_pkg::ADC_BITS;

  src_pkg::samples_t smp;
  logic              is_power;
  logic              is_calib;
  logic              is_sumo;
  logic              active;
  logic              edge_seen;
  logic              in_range;
  logic [19:0]       echo_x17;
  logic [19:0]       range_x1000;
  logic [Adc:0]      mid_sum [src_pkg::LINE_SENSORS];

  assign smp[0] = item_i.line_0[Adc-1:0];
  assign smp[1] = item_i.line_1[Adc-1:0];
  assign smp[2] = item_i.line_2[Adc-1:0];
  assign smp[3] = item_i.line_3[Adc-1:0];
  assign smp[4] = item_i.line_4[Adc-1:0];

  assign is_power = item_i.ir_valid && (item_i.ir_code == src_pkg::CODE_POWER);
  assign is_calib = item_i.ir_valid && (item_i.ir_code == src_pkg::CODE_CALIB);
  assign is_sumo  = item_i.ir_valid && (item_i.ir_code == src_pkg::CODE_SUMO);

  always_comb begin
    flags_o    = flags_i;
    black_we_o = 1'b0;
    thr_o      = thr_i;
    for (int i = 0; i < src_pkg::LINE_SENSORS; i++) begin
      mid_sum[i] = {1'b0, black_i[i]} + {1'b0, smp[i]};
    end
    if (is_power) begin
      flags_o.power = !flags_i.power;
      if (flags_i.power) flags_o.sumo = 1'b0;
    end else if (is_calib) begin
      flags_o.calib_phase = !flags_i.calib_phase;
      if (!flags_i.calib_phase) begin
        black_we_o = 1'b1;
      end else begin
        for (int i = 0; i < src_pkg::LINE_SENSORS; i++) begin
          thr_o[i] = mid_sum[i][Adc:1];
        end
      end
    end else if (is_sumo && flags_i.power) begin
      flags_o.sumo = !flags_i.sumo;
    end
  end

  // edge test sees thresholds after any calibration in this word
  always_comb begin
    edge_seen = 1'b0;
    for (int i = 0; i < src_pkg::LINE_SENSORS; i++) begin
      if (smp[i] < thr_o[i]) edge_seen = 1'b1;
    end
  end

  assign echo_x17    = {5'd0, item_i.echo_us} * 20'd17;
  assign range_x1000 = {11'd0, cfg_i.attack_range_cm} * 20'd1000;
  assign in_range    = (item_i.echo_us <= src_pkg::ECHO_TIMEOUT) &&
                       (echo_x17 >= 20'd1000) && (echo_x17 < range_x1000);

  assign active = flags_o.power && flags_o.sumo;

  always_comb begin
    res0_o.left_drive  = src_pkg::DRV_RELEASE;
    res0_o.right_drive = src_pkg::DRV_RELEASE;
    res0_o.drive_speed = 8'd0;
    res0_o.hold_ms     = 12'd0;
    res0_o.power_state = flags_o.power;
    res0_o.sumo_state  = flags_o.sumo;
    res0_o.last        = 1'b1;
    res1_o             = res0_o;
    res1_o.hold_ms     = cfg_i.pause_ms;
    two_o              = 1'b0;
    if (active) begin
      if (edge_seen) begin
        res0_o.left_drive  = src_pkg::DRV_BACKWARD;
        res0_o.right_drive = src_pkg::DRV_BACKWARD;
        res0_o.drive_speed = cfg_i.backup_speed;
        res0_o.hold_ms     = cfg_i.backup_ms;
        res0_o.last        = 1'b0;
        two_o              = 1'b1;
      end else if (in_range) begin
        res0_o.left_drive  = src_pkg::DRV_FORWARD;
        res0_o.right_drive = src_pkg::DRV_FORWARD;
        res0_o.drive_speed = cfg_i.attack_speed;
      end else begin
        res0_o.left_drive  = src_pkg::DRV_FORWARD;
        res0_o.right_drive = src_pkg::DRV_BACKWARD;
        res0_o.drive_speed = cfg_i.search_speed;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sumo_robot_controller.sv =====
`default_nettype none

// Sumo robot pass controller. Each input word is one control-loop pass; it is
// registered, evaluated combinationally (remote code, calibration, edge, range
// and search decisions) and its one or two result words land in a result
// register. Passes giving one result stream at one per cycle when the output
// side keeps up; an edge pass gives two results and holds the result register
// until both are taken. The first result passes the input register and then
// the result register. Configuration writes are always accepted (cfg_ready_o
// is high) and must be issued while no pass is in flight.

module sumo_robot_controller (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  var src_pkg::in_t                      in_data_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output src_pkg::out_t                         out_data_o,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [src_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire  [src_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);

  localparam int unsigned Adc = src_pkg::ADC_BITS;
  localparam logic [31:0] ThrReset = src_pkg::THR_RESET;

  src_pkg::cfg_t     cfg_q;
  src_pkg::in_t      in_q;
  logic              in_valid_q;
  src_pkg::flags_t   flags_q, flags_d;
  src_pkg::samples_t black_q;
  src_pkg::samples_t thr_q, thr_d;
  logic              black_we;
  src_pkg::out_t     res0_q, res1_q, res0_d, res1_d;
  logic              two_q, two_d;
  logic              res_valid_q;
  logic              res_sel_q;
  logic              res_on_last;
  logic              res_free;
  logic              adv;
  logic              in_fire;
  logic              out_fire;

  assign cfg_ready_o = 1'b1;

  src_pass u_pass (
    .item_i     (in_q),
    .cfg_i      (cfg_q),
    .flags_i    (flags_q),
    .black_i    (black_q),
    .thr_i      (thr_q),
    .flags_o    (flags_d),
    .black_we_o (black_we),
    .thr_o      (thr_d),
    .res0_o     (res0_d),
    .res1_o     (res1_d),
    .two_o      (two_d)
  );

  assign res_on_last = !two_q || res_sel_q;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_sel_q ? res1_q : res0_q;
  assign out_fire    = res_valid_q && out_ready_i;
  assign res_free    = !res_valid_q || (out_fire && res_on_last);
  assign adv         = in_valid_q && res_free;
  assign in_ready_o  = !in_valid_q || adv;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_range_cm <= 9'd40;
      cfg_q.attack_speed    <= 8'd255;
      cfg_q.backup_speed    <= 8'd255;
      cfg_q.search_speed    <= 8'd200;
      cfg_q.backup_ms       <= 12'd500;
      cfg_q.pause_ms        <= 12'd100;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        src_pkg::CFG_ATTACK_RANGE: cfg_q.attack_range_cm <= cfg_data_i[8:0];
        src_pkg::CFG_ATTACK_SPEED: cfg_q.attack_speed    <= cfg_data_i[7:0];
        src_pkg::CFG_BACKUP_SPEED: cfg_q.backup_speed    <= cfg_data_i[7:0];
        src_pkg::CFG_SEARCH_SPEED: cfg_q.search_speed    <= cfg_data_i[7:0];
        src_pkg::CFG_BACKUP_MS:    cfg_q.backup_ms       <= cfg_data_i;
        src_pkg::CFG_PAUSE_MS:     cfg_q.pause_ms        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      flags_q     <= '0;
      res_valid_q <= 1'b0;
      res_sel_q   <= 1'b0;
      for (int i = 0; i < src_pkg::LINE_SENSORS; i++) begin
        thr_q[i] <= ThrReset[Adc-1:0];
      end
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        flags_q     <= flags_d;
        thr_q       <= thr_d;
        res_valid_q <= 1'b1;
        res_sel_q   <= 1'b0;
      end else if (out_fire) begin
        // advance to the second word, or drop the finished pass
        if (res_on_last) res_valid_q <= 1'b0;
        else res_sel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) in_q <= in_data_i;
    if (adv) begin
      res0_q <= res0_d;
      res1_q <= res1_d;
      two_q  <= two_d;
    end
    if (adv && black_we) begin
      black_q[0] <= in_q.line_0[Adc-1:0];
      black_q[1] <= in_q.line_1[Adc-1:0];
      black_q[2] <= in_q.line_2[Adc-1:0];
      black_q[3] <= in_q.line_3[Adc-1:0];
      black_q[4] <= in_q.line_4[Adc-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_sumo_robot_controller.sv =====
module tb_sumo_robot_controller;
  import src_pkg::*;

  typedef struct {
    in_t  word;
    bit   typed;
    out_t want;
  } step_row_t;

  logic                     clk_i     = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_t                      in_word   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_t                     out_word;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  // Shadow of the controller: registers, flags and calibration store.
  logic [8:0]  rng_cm;
  logic [7:0]  atk_spd, bk_spd, srch_spd;
  logic [11:0] bk_ms, ps_ms;
  logic        pwr, sumo_on, cal_ph;
  logic [9:0]  black_lvl [LINE_SENSORS];
  logic [9:0]  thr_lvl [LINE_SENSORS];

  out_t drive_q[$];
  int   src_idle_pct  = 0;
  int   dst_stall_pct = 0;
  int   n_bad = 0, n_pass = 0, n_words = 0, n_edge = 0, n_charge = 0, n_search = 0;

  sumo_robot_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= dst_stall_pct);
  end

  // Work out the motor words one pass gives and queue them.
  task automatic drive_for_pass(input in_t w);
    logic [9:0]  smp [LINE_SENSORS];
    logic        hit_edge;
    logic [31:0] echo_x17, rng_x1000;
    out_t        r;
    smp       = '{w.line_0, w.line_1, w.line_2, w.line_3, w.line_4};
    hit_edge  = 1'b0;
    echo_x17  = 32'(w.echo_us) * 32'd17;
    rng_x1000 = 32'(rng_cm) * 32'd1000;
    n_pass++;
    if (w.ir_valid) begin
      if (w.ir_code == CODE_POWER) begin
        pwr = ~pwr;
        if (!pwr) sumo_on = 1'b0;
      end else if (w.ir_code == CODE_CALIB) begin
        if (!cal_ph) begin
          for (int i = 0; i < LINE_SENSORS; i++) black_lvl[i] = smp[i];
        end else begin
          for (int i = 0; i < LINE_SENSORS; i++)
            thr_lvl[i] = 10'(({1'b0, black_lvl[i]} + {1'b0, smp[i]}) >> 1);
        end
        cal_ph = ~cal_ph;
      end else if (pwr && w.ir_code == CODE_SUMO) begin
        sumo_on = ~sumo_on;
      end
    end
    r             = '0;
    r.left_drive  = DRV_RELEASE;
    r.right_drive = DRV_RELEASE;
    r.power_state = pwr;
    r.sumo_state  = sumo_on;
    r.last        = 1'b1;
    if (!(pwr && sumo_on)) begin
      drive_q.push_back(r);
      return;
    end
    for (int i = 0; i < LINE_SENSORS; i++)
      if (smp[i] < thr_lvl[i]) hit_edge = 1'b1;
    if (hit_edge) begin
      // back off the ring edge, then sit released
      r.left_drive  = DRV_BACKWARD;
      r.right_drive = DRV_BACKWARD;
      r.drive_speed = bk_spd;
      r.hold_ms     = bk_ms;
      r.last        = 1'b0;
      drive_q.push_back(r);
      r.left_drive  = DRV_RELEASE;
      r.right_drive = DRV_RELEASE;
      r.drive_speed = '0;
      r.hold_ms     = ps_ms;
      r.last        = 1'b1;
      n_edge++;
    end else if (w.echo_us != '0 && w.echo_us <= ECHO_TIMEOUT &&
                 echo_x17 >= 32'd1000 && echo_x17 < rng_x1000) begin
      r.left_drive  = DRV_FORWARD;
      r.right_drive = DRV_FORWARD;
      r.drive_speed = atk_spd;
      n_charge++;
    end else begin
      r.left_drive  = DRV_FORWARD;
      r.right_drive = DRV_BACKWARD;
      r.drive_speed = srch_spd;
      n_search++;
    end
    drive_q.push_back(r);
  endtask

  task automatic cmp_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      n_bad++;
      if (n_bad <= 10) $display("mismatch in %s: expected %0d, got %0d", fname, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      n_words++;
      if (drive_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result word %h", out_word);
      end else begin
        want = drive_q.pop_front();
        cmp_field("left_drive",  32'(want.left_drive),  32'(out_word.left_drive));
        cmp_field("right_drive", 32'(want.right_drive), 32'(out_word.right_drive));
        cmp_field("drive_speed", 32'(want.drive_speed), 32'(out_word.drive_speed));
        cmp_field("hold_ms",     32'(want.hold_ms),     32'(out_word.hold_ms));
        cmp_field("power_state", 32'(want.power_state), 32'(out_word.power_state));
        cmp_field("sumo_state",  32'(want.sumo_state),  32'(out_word.sumo_state));
        cmp_field("last",        32'(want.last),        32'(out_word.last));
      end
    end
  end

  // Entered and left at a falling edge; valid stays high into the next word.
  task automatic send_pass(input in_t w, input bit typed, input out_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready);
    drive_for_pass(w);
    if (typed) drive_q[drive_q.size()-1] = want;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_ATTACK_RANGE: rng_cm   = val[8:0];
      CFG_ATTACK_SPEED: atk_spd  = val[7:0];
      CFG_BACKUP_SPEED: bk_spd   = val[7:0];
      CFG_SEARCH_SPEED: srch_spd = val[7:0];
      CFG_BACKUP_MS:    bk_ms    = val;
      CFG_PAUSE_MS:     ps_ms    = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_regs(input int unsigned range_cm, input int unsigned atk,
                          input int unsigned bk, input int unsigned srch,
                          input int unsigned bkms, input int unsigned psms);
    write_reg(CFG_ATTACK_RANGE, 12'(range_cm));
    write_reg(CFG_ATTACK_SPEED, 12'(atk));
    write_reg(CFG_BACKUP_SPEED, 12'(bk));
    write_reg(CFG_SEARCH_SPEED, 12'(srch));
    write_reg(CFG_BACKUP_MS,    12'(bkms));
    write_reg(CFG_PAUSE_MS,     12'(psms));
    cfg_valid <= 1'b0;
  endtask

  // Wait for every queued word, bounded, then let the pipeline settle.
  task automatic drain(input int limit_cycles);
    int waited;
    waited = 0;
    while (drive_q.size() != 0 && waited < limit_cycles) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(negedge clk_i);
  endtask

  function automatic in_t pass_w(input logic v, input logic [31:0] code,
                                 input int l0, input int l1, input int l2,
                                 input int l3, input int l4, input int echo);
    in_t w;
    w.ir_valid = v;
    w.ir_code  = code;
    w.line_0   = 10'(l0);
    w.line_1   = 10'(l1);
    w.line_2   = 10'(l2);
    w.line_3   = 10'(l3);
    w.line_4   = 10'(l4);
    w.echo_us  = 15'(echo);
    return w;
  endfunction

  function automatic out_t idle_word(input logic p, input logic s);
    out_t r;
    r             = '0;
    r.left_drive  = DRV_RELEASE;
    r.right_drive = DRV_RELEASE;
    r.power_state = p;
    r.sumo_state  = s;
    r.last        = 1'b1;
    return r;
  endfunction

  // Mostly drive toward powered sumo mode, then mix edges, targets and noise.
  function automatic in_t gen_pass();
    in_t         w;
    int unsigned r, m, k, e;
    int          b;
    logic [9:0]  smp [LINE_SENSORS];
    r          = $urandom_range(99);
    w.ir_valid = 1'b0;
    w.ir_code  = $urandom();
    if (!pwr && r < 35) begin
      w.ir_valid = 1'b1;
      w.ir_code  = CODE_POWER;
    end else if (pwr && !sumo_on && r < 35) begin
      w.ir_valid = 1'b1;
      w.ir_code  = CODE_SUMO;
    end else if (pwr && sumo_on && r < 2) begin
      w.ir_valid = 1'b1;
      w.ir_code  = CODE_POWER;
    end else if (pwr && sumo_on && r < 4) begin
      w.ir_valid = 1'b1;
      w.ir_code  = CODE_SUMO;
    end else if (r >= 40 && r < 46) begin
      w.ir_valid = 1'b1;
      w.ir_code  = CODE_CALIB;
    end else if (r >= 46 && r < 50) begin
      w.ir_valid = 1'b1;
    end else if (r >= 50 && r < 53) begin
      w.ir_code = CODE_CALIB;
    end
    m = $urandom_range(9);
    for (int i = 0; i < LINE_SENSORS; i++)
      smp[i] = (m < 6) ? 10'($urandom_range(1023, thr_lvl[i])) : 10'($urandom_range(1023));
    if (m == 6 || m == 7) begin
      k = $urandom_range(LINE_SENSORS-1);
      if (thr_lvl[k] != '0) smp[k] = 10'($urandom_range(thr_lvl[k] - 1));
    end
    w.line_0 = smp[0];
    w.line_1 = smp[1];
    w.line_2 = smp[2];
    w.line_3 = smp[3];
    w.line_4 = smp[4];
    b = (int'(rng_cm) * 1000 + 16) / 17;
    case ($urandom_range(9))
      0:       e = 0;
      1:       e = $urandom_range(57, 60);
      2, 3:    e = $urandom_range(b + 1, (b > 0) ? b - 1 : 0);
      4, 5, 6: e = $urandom_range(1, 6000);
      7:       e = $urandom_range(20000);
      8:       e = $urandom_range(19999, 20001);
      default: e = $urandom_range(20001, 32767);
    endcase
    w.echo_us = 15'(e);
    return w;
  endfunction

  initial begin
    step_row_t tab[$];
    rng_cm   = 9'd40;
    atk_spd  = 8'd255;
    bk_spd   = 8'd255;
    srch_spd = 8'd200;
    bk_ms    = 12'd500;
    ps_ms    = 12'd100;
    pwr      = 1'b0;
    sumo_on  = 1'b0;
    cal_ph   = 1'b0;
    for (int i = 0; i < LINE_SENSORS; i++) begin
      black_lvl[i] = '0;
      thr_lvl[i]   = 10'(THR_RESET);
    end

    tab.push_back('{pass_w(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, idle_word(0, 0)});
    // sumo code is ignored while powered off
    tab.push_back('{pass_w(1, CODE_SUMO, 1023, 1023, 1023, 1023, 1023, 100), 1'b1, idle_word(0, 0)});
    tab.push_back('{pass_w(1, CODE_POWER, 1023, 1023, 1023, 1023, 1023, 0), 1'b1, idle_word(1, 0)});
    tab.push_back('{pass_w(1, 32'hFFFF_FFFF, 1023, 1023, 1023, 1023, 1023, 0), 1'b1,
                    idle_word(1, 0)});
    tab.push_back('{pass_w(1, CODE_SUMO, 1023, 1023, 1023, 1023, 1023, 0), 1'b0, '0});
    tab.push_back('{pass_w(0, CODE_POWER, 1023, 1023, 1023, 1023, 1023, 58), 1'b0, '0});
    tab.push_back('{pass_w(0, 0, 1023, 1023, 1023, 1023, 1023, 59), 1'b0, '0});
    tab.push_back('{pass_w(0, 0, 1023, 1023, 1023, 1023, 1023, 2352), 1'b0, '0});
    tab.push_back('{pass_w(0, 0, 1023, 1023, 1023, 1023, 1023, 2353), 1'b0, '0});
    tab.push_back('{pass_w(0, 0, 1023, 1023, 1023, 1023, 1023, 20000), 1'b0, '0});
    tab.push_back('{pass_w(0, 0, 1023, 1023, 1023, 1023, 1023, 32767), 1'b0, '0});
    tab.push_back('{pass_w(0, 0, 499, 1023, 1023, 1023, 1023, 100), 1'b0, '0});
    tab.push_back('{pass_w(0, 0, 1023, 1023, 1023, 1023, 0, 100), 1'b0, '0});
    tab.push_back('{pass_w(0, 0, 500, 500, 500, 500, 500, 1000), 1'b0, '0});
    // calibration pair while active: dark samples, then light ones
    tab.push_back('{pass_w(1, CODE_CALIB, 100, 0, 1023, 512, 1, 0), 1'b0, '0});
    tab.push_back('{pass_w(1, CODE_CALIB, 1023, 1023, 1023, 1023, 1023, 59), 1'b0, '0});
    tab.push_back('{pass_w(0, 0, 1023, 1023, 1023, 766, 1023, 0), 1'b0, '0});
    tab.push_back('{pass_w(0, 0, 1023, 1023, 1022, 1023, 1023, 0), 1'b0, '0});
    tab.push_back('{pass_w(1, 0, 1023, 1023, 1023, 1023, 1023, 1), 1'b0, '0});
    // power off clears sumo mode
    tab.push_back('{pass_w(1, CODE_POWER, 1023, 1023, 1023, 1023, 1023, 0), 1'b1,
                    idle_word(0, 0)});
    tab.push_back('{pass_w(1, CODE_POWER, 0, 0, 0, 0, 0, 0), 1'b1, idle_word(1, 0)});
    tab.push_back('{pass_w(1, CODE_SUMO, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    tab.push_back('{pass_w(1, CODE_POWER, 1023, 1023, 1023, 1023, 1023, 0), 1'b1,
                    idle_word(0, 0)});
    // calibration also runs while powered off
    tab.push_back('{pass_w(1, CODE_CALIB, 0, 0, 0, 0, 0, 0), 1'b1, idle_word(0, 0)});
    tab.push_back('{pass_w(1, CODE_CALIB, 1023, 1023, 1023, 1023, 1023, 0), 1'b1,
                    idle_word(0, 0)});

    repeat (6) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    foreach (tab[i]) send_pass(tab[i].word, tab[i].typed, tab[i].want);
    in_valid <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      drain(2000);
      case (ph)
        0: begin
          set_regs(340, 255, 255, 255, 4095, 4095);
          src_idle_pct  = 0;
          dst_stall_pct = 0;
        end
        1: begin
          set_regs(1, 0, 0, 0, 0, 0);
          src_idle_pct  = 61;
          dst_stall_pct = 0;
        end
        2: begin
          // zero range: never charges
          set_regs(0, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                   $urandom_range(4095), $urandom_range(4095));
          src_idle_pct  = 0;
          dst_stall_pct = 61;
        end
        default: begin
          set_regs($urandom_range(511), $urandom_range(255), $urandom_range(255),
                   $urandom_range(255), $urandom_range(4095), $urandom_range(4095));
          src_idle_pct  = 21;
          dst_stall_pct = 21;
        end
      endcase
      for (int n = 0; n < 200; n++) send_pass(gen_pass(), 1'b0, '0);
      in_valid <= 1'b0;
    end

    drain(2000);
    n_bad += drive_q.size();
    $display("ran %0d passes (%0d edge, %0d charge, %0d search), %0d result words checked",
             n_pass, n_edge, n_charge, n_search, n_words);
    $display("under reset, maximum, minimum, zero-range and random register settings");
    if (n_bad == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d words outstanding", drive_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
